// ===== hdl/sorted_list_intersection_core_macros.svh =====
// Assertion macros used by the checker of the sorted list intersection core.
`ifndef SORTED_LIST_INTERSECTION_CORE_MACROS_SVH
`define SORTED_LIST_INTERSECTION_CORE_MACROS_SVH

// Implication property checked on every rising clock edge outside reset.
`define SLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define SLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sli_pkg.sv =====
// Package with the word types and request codes of the sorted list intersection core.
`timescale 1ns / 1ps

package sli_pkg;

  // Width of a document id.
  localparam int IdW = 31;

  // Request codes carried in the req_type field.
  localparam logic [1:0] ReqLoadFirst  = 2'd0;
  localparam logic [1:0] ReqLoadSecond = 2'd1;
  localparam logic [1:0] ReqRun        = 2'd2;

  // Input word: one request.
  typedef struct packed {
    logic [1:0]     req_type;
    logic [IdW-1:0] doc_id;
  } in_word_t;

  // Output word: one result of a run.
  typedef struct packed {
    logic [IdW-1:0] match_doc_id;
    logic           match_valid;
    logic           overflow;
    logic           last;
  } out_word_t;

endpackage

// ===== hdl/sorted_list_intersection_core.sv =====
// Top level of the sorted list intersection core: two id memories and the merge walk.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    sli_pkg::in_word_t  (req_type, doc_id)
// out       output     out_valid_o / out_ready_i  sli_pkg::out_word_t (match_doc_id, ...)
//
// A load request appends its id, or flags overflow on a full list; an unknown code is dropped.
// Each pointer step of a run passes StRead (memory read), then StCmp (compare); a run takes
// at most first count + second count - 1 steps, then StFlush sends the final word.
// A run with an empty list goes to StFlush and sends the no-match word. Reset clears the
// counts, the overflow flag and the control state; the memories are not cleared.
// A match step and the final word wait while the output register holds an untaken word.
module sorted_list_intersection_core #(
  parameter int LIST_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sli_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sli_pkg::out_word_t out_word_o
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DepthVal = CW'(LIST_DEPTH);

  // Controller states.
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StCmp   = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [CW-1:0]           a_cnt_q, a_cnt_d;
  logic [CW-1:0]           b_cnt_q, b_cnt_d;
  logic                    ovf_q, ovf_d;
  logic [CW-1:0]           i_q, i_d;
  logic [CW-1:0]           j_q, j_d;
  logic [sli_pkg::IdW-1:0] hold_q, hold_d;
  logic                    hold_vld_q, hold_vld_d;
  logic                    out_vld_q, out_vld_d;
  sli_pkg::out_word_t      out_word_q, out_word_d;
  logic [sli_pkg::IdW-1:0] a_rd_q, b_rd_q;
  logic                    a_we, b_we;
  logic                    in_acc, out_free;
  logic [CW-1:0]           i_inc, j_inc;

  logic [sli_pkg::IdW-1:0] a_mem [LIST_DEPTH];
  logic [sli_pkg::IdW-1:0] b_mem [LIST_DEPTH];

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;
  assign i_inc       = i_q + 1'b1;
  assign j_inc       = j_q + 1'b1;

  // First list memory: append at the fill count, read at the first pointer.
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_cnt_q[AW-1:0]] <= in_word_i.doc_id;
    end
    a_rd_q <= a_mem[i_q[AW-1:0]];
  end

  // Second list memory: append at the fill count, read at the second pointer.
  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_cnt_q[AW-1:0]] <= in_word_i.doc_id;
    end
    b_rd_q <= b_mem[j_q[AW-1:0]];
  end

  // Next-state logic of the loader and the merge walk.
  always_comb begin
    state_d    = state_q;
    a_cnt_d    = a_cnt_q;
    b_cnt_d    = b_cnt_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    out_word_d = out_word_q;
    a_we       = 1'b0;
    b_we       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (in_word_i.req_type)
            sli_pkg::ReqLoadFirst: begin
              if (a_cnt_q < DepthVal) begin
                a_we    = 1'b1;
                a_cnt_d = a_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            sli_pkg::ReqLoadSecond: begin
              if (b_cnt_q < DepthVal) begin
                b_we    = 1'b1;
                b_cnt_d = b_cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            sli_pkg::ReqRun: begin
              i_d        = '0;
              j_d        = '0;
              hold_vld_d = 1'b0;
              if ((a_cnt_q == '0) || (b_cnt_q == '0)) begin
                state_d = StFlush;
              end else begin
                state_d = StRead;
              end
            end
            default: begin
              // Unknown request codes are dropped.
            end
          endcase
        end
      end

      StRead: begin
        // Both memories present the ids under the pointers in the next cycle.
        state_d = StCmp;
      end

      StCmp: begin
        priority if (a_rd_q == b_rd_q) begin
          // A match is held back until the next one shows whether it is the last.
          if (out_free) begin
            if (hold_vld_q) begin
              out_vld_d               = 1'b1;
              out_word_d.match_doc_id = hold_q;
              out_word_d.match_valid  = 1'b1;
              out_word_d.overflow     = ovf_q;
              out_word_d.last         = 1'b0;
            end
            hold_d     = a_rd_q;
            hold_vld_d = 1'b1;
            i_d        = i_inc;
            j_d        = j_inc;
            state_d    = ((i_inc >= a_cnt_q) || (j_inc >= b_cnt_q)) ? StFlush : StRead;
          end
        end else if (a_rd_q < b_rd_q) begin
          i_d     = i_inc;
          state_d = (i_inc >= a_cnt_q) ? StFlush : StRead;
        end else begin
          j_d     = j_inc;
          state_d = (j_inc >= b_cnt_q) ? StFlush : StRead;
        end
      end

      StFlush: begin
        // Send the held match, or the no-match marker, as the last word of the run.
        if (out_free) begin
          out_vld_d               = 1'b1;
          out_word_d.match_doc_id = hold_vld_q ? hold_q : '0;
          out_word_d.match_valid  = hold_vld_q;
          out_word_d.overflow     = ovf_q;
          out_word_d.last         = 1'b1;
          a_cnt_d                 = '0;
          b_cnt_d                 = '0;
          ovf_d                   = 1'b0;
          hold_vld_d              = 1'b0;
          state_d                 = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      a_cnt_q    <= '0;
      b_cnt_q    <= '0;
      ovf_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      a_cnt_q    <= a_cnt_d;
      b_cnt_q    <= b_cnt_d;
      ovf_q      <= ovf_d;
      i_q        <= i_d;
      j_q        <= j_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_word_q <= out_word_d;
  end

endmodule

// ===== hdl/sli_checker.sv =====
// Port checker of the sorted list intersection core and its bind statement.
`timescale 1ns / 1ps
`include "sorted_list_intersection_core_macros.svh"

module sli_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input sli_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sli_pkg::out_word_t out_word_o
);

  // A stalled output word stays up and unchanged.
  `SLI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o), "output word dropped or changed while stalled")

  // The no-match marker is always the last word and carries a zero id.
  `SLI_ASSERT_IMP(a_marker_last, clk_i, rst_ni, out_valid_o && !out_word_o.match_valid, out_word_o.last && (out_word_o.match_doc_id == '0), "no-match marker malformed")

  // An accepted run request keeps the input closed in the next cycle.
  `SLI_ASSERT_NEXT(a_run_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (in_word_i.req_type == sli_pkg::ReqRun), !in_ready_o, "input open right after a run request")

  // While a word that is not the last is taken, the run is still in progress.
  `SLI_ASSERT_IMP(a_run_open, clk_i, rst_ni, out_valid_o && out_ready_i && !out_word_o.last, !in_ready_o, "input open before the last word of a run")

endmodule

bind sorted_list_intersection_core sli_checker u_sli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
